[rtl/core/qpsc_pkg.sv]
// shared types, constants and the coil table for the beam centering block
`timescale 1ns / 1ps

package qpsc_pkg;

    // sample and fraction format
    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 15;

    // register field widths
    localparam int STEPS_W  = 13;
    localparam int TGT_W    = 16;
    localparam int TOL_W    = 15;
    localparam int MOVES_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // result field widths
    localparam int COIL_W   = 4;
    localparam int STATUS_W = 3;
    localparam int PHASE_W  = 3;

    // arithmetic widths derived from the sample format
    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int DIFF_W = SUM_W + 1;
    localparam int ERR_W  = SUM_W + ((FRACTION_BITS > TGT_W) ? FRACTION_BITS : TGT_W) + 2;
    localparam int TPROD_W = TGT_W + SUM_W + 1;
    localparam int LPROD_W = TOL_W + SUM_W;

    // stream packing
    localparam int IN_FIELDS_W  = 4 * SAMPLE_BITS;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = COIL_W + 1 + STEPS_W + STATUS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // budget limit
    localparam logic [STEPS_W-1:0] BUDGET_MAX = STEPS_W'(4096);

    // register reset values
    localparam logic [STEPS_W-1:0] INIT_STEPS_RST = STEPS_W'(2048);
    localparam logic [TGT_W-1:0]   TARGET_RST     = '0;
    localparam logic [TOL_W-1:0]   TOL_RST        = TOL_W'(33);
    localparam logic [MOVES_W-1:0] MAX_MOVES_RST  = MOVES_W'(65535);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_STEPS = 2'd0,
        CFG_TARGET        = 2'd1,
        CFG_TOLERANCE     = 2'd2,
        CFG_MAX_MOVES     = 2'd3
    } qpsc_cfg_idx_t;

    // search status
    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_MOVING  = 3'd1,
        ST_ALIGNED = 3'd2,
        ST_LIMIT   = 3'd3,
        ST_NOBEAM  = 3'd4
    } qpsc_status_t;

    // outcome of the position test
    typedef struct packed {
        logic no_beam;
        logic aligned;
        logic err_pos;
    } qpsc_eval_t;

    // one result transaction
    typedef struct packed {
        qpsc_status_t         status;
        logic [STEPS_W-1:0]   step_budget;
        logic                 turn_reverse;
        logic [COIL_W-1:0]    coil_pattern;
    } qpsc_result_t;

    // sequencer state seen by the top-level checks
    typedef struct packed {
        qpsc_status_t         status;
        logic [STEPS_W-1:0]   budget;
        logic [STEPS_W-1:0]   steps_left;
    } qpsc_mon_t;

    // half-step coil pattern for a phase index
    function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

[rtl/core/qpsc_eval.sv]
// position error and tolerance test on one set of quadrant samples
`timescale 1ns / 1ps

module qpsc_eval (
    input  logic [qpsc_pkg::SAMPLE_BITS-1:0] quad_a,
    input  logic [qpsc_pkg::SAMPLE_BITS-1:0] quad_b,
    input  logic [qpsc_pkg::SAMPLE_BITS-1:0] quad_c,
    input  logic [qpsc_pkg::SAMPLE_BITS-1:0] quad_d,
    input  logic [qpsc_pkg::TGT_W-1:0]       target_position,
    input  logic [qpsc_pkg::TOL_W-1:0]       tolerance,
    output qpsc_pkg::qpsc_eval_t             result
);

    logic [qpsc_pkg::SUM_W-1:0]          sum;
    logic [qpsc_pkg::SAMPLE_BITS:0]      pair_bd;
    logic [qpsc_pkg::SAMPLE_BITS:0]      pair_ac;
    logic signed [qpsc_pkg::DIFF_W-1:0]  diff;
    logic signed [qpsc_pkg::ERR_W-1:0]   scaled;
    logic signed [qpsc_pkg::TPROD_W-1:0] target_prod;
    logic signed [qpsc_pkg::ERR_W-1:0]   err;
    logic [qpsc_pkg::ERR_W-1:0]          mag;
    logic [qpsc_pkg::LPROD_W-1:0]        tol_prod;

    // quadrant sums
    assign pair_bd = {1'b0, quad_b} + {1'b0, quad_d};
    assign pair_ac = {1'b0, quad_a} + {1'b0, quad_c};
    assign sum     = qpsc_pkg::SUM_W'(pair_bd) + qpsc_pkg::SUM_W'(pair_ac);

    // error = diff scaled up minus target times sum
    assign diff = $signed(qpsc_pkg::DIFF_W'(pair_bd)) - $signed(qpsc_pkg::DIFF_W'(pair_ac));
    assign scaled = qpsc_pkg::ERR_W'(diff) <<< qpsc_pkg::FRACTION_BITS;
    assign target_prod = $signed(target_position) * $signed({1'b0, sum});
    assign err = scaled - qpsc_pkg::ERR_W'(target_prod);

    // magnitude against tolerance times sum
    assign mag      = err[qpsc_pkg::ERR_W-1] ? qpsc_pkg::ERR_W'(-err) : qpsc_pkg::ERR_W'(err);
    assign tol_prod = tolerance * sum;

    assign result.no_beam = (sum == '0);
    assign result.aligned = (mag <= qpsc_pkg::ERR_W'(tol_prod));
    assign result.err_pos = !err[qpsc_pkg::ERR_W-1] && (err != '0);

endmodule

[rtl/core/qpsc_seq.sv]
// search sequencer: move state, step budget, phase and coil drive
`timescale 1ns / 1ps

module qpsc_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            fire,
    input  logic                            start_req,
    input  qpsc_pkg::qpsc_eval_t            eval_res,
    input  logic [qpsc_pkg::STEPS_W-1:0]    initial_steps,
    input  logic [qpsc_pkg::MOVES_W-1:0]    max_moves,
    output qpsc_pkg::qpsc_result_t          result,
    output qpsc_pkg::qpsc_mon_t             mon
);

    qpsc_pkg::qpsc_status_t           status_reg, status_next;
    logic [qpsc_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic                             rev_reg, rev_next;
    logic [qpsc_pkg::STEPS_W-1:0]     budget_reg, budget_next;
    logic [qpsc_pkg::STEPS_W-1:0]     steps_reg, steps_next;
    logic [qpsc_pkg::MOVES_W-1:0]     count_reg, count_next;

    logic                             stepping;
    logic                             do_eval;
    logic                             first_test;
    logic                             move_ok;
    logic [qpsc_pkg::STEPS_W-1:0]     init_budget;
    logic [qpsc_pkg::STEPS_W-1:0]     base_budget;
    logic [qpsc_pkg::STEPS_W-1:0]     halved;
    logic [qpsc_pkg::STEPS_W-1:0]     steps_dec;
    logic [qpsc_pkg::MOVES_W-1:0]     count_base;
    logic [qpsc_pkg::COIL_W-1:0]      coil;

    // clamp the first budget into 1 .. BUDGET_MAX
    always_comb begin
        if (initial_steps == '0) begin
            init_budget = qpsc_pkg::STEPS_W'(1);
        end else if (initial_steps > qpsc_pkg::BUDGET_MAX) begin
            init_budget = qpsc_pkg::BUDGET_MAX;
        end else begin
            init_budget = initial_steps;
        end
    end

    // when a test happens and what it starts from
    always_comb begin
        stepping    = fire && !start_req && (status_reg == qpsc_pkg::ST_MOVING);
        first_test  = fire && start_req;
        steps_dec   = (steps_reg != '0) ? steps_reg - qpsc_pkg::STEPS_W'(1) : steps_reg;
        do_eval     = first_test || (stepping && (steps_dec == '0));
        base_budget = first_test ? init_budget : budget_reg;
        count_base  = first_test ? '0 : count_reg;
        move_ok     = !eval_res.no_beam && !eval_res.aligned && (count_base < max_moves);
        halved      = base_budget >> 1;
    end

    // next state of the search
    always_comb begin
        status_next = status_reg;
        if (do_eval) begin
            if (eval_res.no_beam) begin
                status_next = qpsc_pkg::ST_NOBEAM;
            end else if (eval_res.aligned) begin
                status_next = qpsc_pkg::ST_ALIGNED;
            end else if (count_base >= max_moves) begin
                status_next = qpsc_pkg::ST_LIMIT;
            end else begin
                status_next = qpsc_pkg::ST_MOVING;
            end
        end
    end

    // phase, budget, direction and counters
    always_comb begin
        phase_next  = phase_reg;
        rev_next    = rev_reg;
        budget_next = first_test ? init_budget : budget_reg;
        steps_next  = steps_reg;
        count_next  = count_base;
        if (stepping) begin
            phase_next = rev_reg ? phase_reg - qpsc_pkg::PHASE_W'(1)
                                 : phase_reg + qpsc_pkg::PHASE_W'(1);
            steps_next = steps_dec;
        end
        if (do_eval) begin
            if (move_ok) begin
                if (!first_test && (eval_res.err_pos != rev_reg)) begin
                    budget_next = (halved == '0) ? qpsc_pkg::STEPS_W'(1) : halved;
                end else begin
                    budget_next = base_budget;
                end
                rev_next   = eval_res.err_pos;
                steps_next = budget_next;
                count_next = count_base + qpsc_pkg::MOVES_W'(1);
            end else begin
                steps_next = '0;
            end
        end
    end

    // coil drive of this transaction
    always_comb begin
        coil = stepping ? qpsc_pkg::coil_lookup(phase_reg) : '0;
    end

    // state registers, updated once per processed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= qpsc_pkg::ST_IDLE;
            phase_reg  <= '0;
            rev_reg    <= 1'b0;
            budget_reg <= '0;
            steps_reg  <= '0;
            count_reg  <= '0;
        end else if (fire) begin
            status_reg <= status_next;
            phase_reg  <= phase_next;
            rev_reg    <= rev_next;
            budget_reg <= budget_next;
            steps_reg  <= steps_next;
            count_reg  <= count_next;
        end
    end

    assign result.status       = status_next;
    assign result.step_budget  = budget_next;
    assign result.turn_reverse = rev_next;
    assign result.coil_pattern = coil;

    assign mon.status     = status_reg;
    assign mon.budget     = budget_reg;
    assign mon.steps_left = steps_reg;

endmodule

[rtl/core/quad_photodiode_stepper_centering.sv]
// top level of the quad photodiode beam centering stepper search
`timescale 1ns / 1ps

// Usage
// Each input transaction is one step-timer tick carrying four quadrant samples
// in s_tdata (A lowest) and a restart flag in s_tuser. Every tick gives exactly
// one result transaction: the coil pattern to drive for both motors, the
// current direction, the step budget in use and the search status.
// A tick with s_tuser high restarts the search from the register settings.
// A tick passes through an input register, then the position test and
// sequencer logic into the result register. One tick is taken every cycle
// while m_tready is high; the rate is set by that single registered pass.
// The input stage keeps accepting while a result waits, until both registers
// hold data; a stall on m_tready then holds the result and drops s_tready.
// Registers are written through cfg_we / cfg_index / cfg_wdata, one per cycle.
// A synchronous active-low reset empties both registers, loads the register
// defaults and leaves the search idle with a zero budget.

module quad_photodiode_stepper_centering (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input ticks
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [qpsc_pkg::IN_DATA_W-1:0]    s_tdata,  // quad_a, quad_b, quad_c, quad_d
    input  logic                              s_tuser,  // start_req
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qpsc_pkg::OUT_DATA_W-1:0]   m_tdata,  // coil_pattern, turn_reverse,
                                                        // step_budget, status
    // register writes
    input  logic                              cfg_we,
    input  logic [qpsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qpsc_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int SB = qpsc_pkg::SAMPLE_BITS;

    logic [qpsc_pkg::STEPS_W-1:0]  init_steps_reg;
    logic [qpsc_pkg::TGT_W-1:0]    target_reg;
    logic [qpsc_pkg::TOL_W-1:0]    tol_reg;
    logic [qpsc_pkg::MOVES_W-1:0]  max_moves_reg;

    logic                          in_valid_reg, in_valid_next;
    logic                          in_start_reg;
    logic [SB-1:0]                 in_a_reg, in_b_reg, in_c_reg, in_d_reg;

    logic                          out_valid_reg, out_valid_next;
    qpsc_pkg::qpsc_result_t        out_reg;

    logic                          out_free;
    logic                          fire;
    logic                          in_take;
    qpsc_pkg::qpsc_eval_t          eval_res;
    qpsc_pkg::qpsc_result_t        result;
    qpsc_pkg::qpsc_mon_t           mon;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_steps_reg <= qpsc_pkg::INIT_STEPS_RST;
            target_reg     <= qpsc_pkg::TARGET_RST;
            tol_reg        <= qpsc_pkg::TOL_RST;
            max_moves_reg  <= qpsc_pkg::MAX_MOVES_RST;
        end else if (cfg_we) begin
            unique case (qpsc_pkg::qpsc_cfg_idx_t'(cfg_index))
                qpsc_pkg::CFG_INITIAL_STEPS: init_steps_reg <= cfg_wdata[qpsc_pkg::STEPS_W-1:0];
                qpsc_pkg::CFG_TARGET:        target_reg     <= cfg_wdata[qpsc_pkg::TGT_W-1:0];
                qpsc_pkg::CFG_TOLERANCE:     tol_reg        <= cfg_wdata[qpsc_pkg::TOL_W-1:0];
                qpsc_pkg::CFG_MAX_MOVES:     max_moves_reg  <= cfg_wdata[qpsc_pkg::MOVES_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake between the two stages
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_start_reg <= s_tuser;
            in_a_reg     <= s_tdata[SB-1:0];
            in_b_reg     <= s_tdata[2*SB-1:SB];
            in_c_reg     <= s_tdata[3*SB-1:2*SB];
            in_d_reg     <= s_tdata[4*SB-1:3*SB];
        end
    end

    // position test
    qpsc_eval u_eval (
        .quad_a          (in_a_reg),
        .quad_b          (in_b_reg),
        .quad_c          (in_c_reg),
        .quad_d          (in_d_reg),
        .target_position (target_reg),
        .tolerance       (tol_reg),
        .result          (eval_res)
    );

    // search sequencer
    qpsc_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .start_req     (in_start_reg),
        .eval_res      (eval_res),
        .initial_steps (init_steps_reg),
        .max_moves     (max_moves_reg),
        .result        (result),
        .mon           (mon)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = qpsc_pkg::OUT_DATA_W'({out_reg.status, out_reg.step_budget,
                                             out_reg.turn_reverse, out_reg.coil_pattern});

    // a running move always has a nonzero budget and steps left
    a_moving_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        mon.status == qpsc_pkg::ST_MOVING |-> mon.budget != '0 && mon.steps_left != '0)
        else $error("moving with empty budget or no steps left");

    // steps left never exceed the budget of the move
    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mon.status == qpsc_pkg::ST_MOVING |-> mon.steps_left <= mon.budget)
        else $error("steps left above budget");

    // a held tick with a free result register is always processed
    a_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("input stage stuck with free result register");

    // the budget never leaves its range once set
    a_budget_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> result.step_budget <= qpsc_pkg::BUDGET_MAX)
        else $error("step budget out of range");

endmodule

[sim/qpsc_search_checker.sv]
// checker that predicts and compares every result of the beam centering block
`timescale 1ns / 1ps

module qpsc_search_checker
    import qpsc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // quad_a, quad_b, quad_c, quad_d
    input  logic                   s_tuser,   // start_req
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_DATA_W-1:0]  m_tdata,   // coil_pattern, turn_reverse,
                                              // step_budget, status
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    output int                     errors,
    output int                     pending
);

    // half-step drive sequence, phase 0 in the lowest nibble
    localparam logic [31:0] HALF_STEP_SEQ = 32'h98C4_6231;

    // register copies
    logic [STEPS_W-1:0]       init_steps_q;
    logic signed [TGT_W-1:0]  target_q;
    logic [TOL_W-1:0]         tol_q;
    logic [MOVES_W-1:0]       max_moves_q;

    // search state copy
    logic [PHASE_W-1:0]  phase_q;
    logic                rev_q;
    logic [STEPS_W-1:0]  budget_q;
    logic [STEPS_W-1:0]  steps_left_q;
    logic [MOVES_W-1:0]  moves_q;
    qpsc_status_t        status_q;

    qpsc_result_t expected_results[$];
    int fail_count   = 0;
    int outstanding  = 0;
    int result_index = 0;

    assign errors  = fail_count;
    assign pending = outstanding;

    task report_mismatch(input string field, input int got, input int want);
        if (fail_count < 100)
            $display("result %0d: %s got %0d expected %0d", result_index, field, got, want);
        fail_count++;
    endtask

    // position test at a start or at the end of a move
    function automatic void test_position(input logic [IN_DATA_W-1:0] quads,
                                          input logic first);
        longint qa, qb, qc, qd, sum, err, mag;
        logic dir;
        qa  = longint'(quads[0 +: SAMPLE_BITS]);
        qb  = longint'(quads[SAMPLE_BITS +: SAMPLE_BITS]);
        qc  = longint'(quads[2*SAMPLE_BITS +: SAMPLE_BITS]);
        qd  = longint'(quads[3*SAMPLE_BITS +: SAMPLE_BITS]);
        sum = qa + qb + qc + qd;
        err = ((qb + qd) - (qa + qc)) * (longint'(1) << FRACTION_BITS)
              - longint'(target_q) * sum;
        mag = (err < 0) ? -err : err;
        dir = (err > 0);
        if (sum == 0) begin
            status_q     = ST_NOBEAM;
            steps_left_q = '0;
        end else if (mag <= longint'(tol_q) * sum) begin
            status_q     = ST_ALIGNED;
            steps_left_q = '0;
        end else if (moves_q >= max_moves_q) begin
            status_q     = ST_LIMIT;
            steps_left_q = '0;
        end else begin
            // a reversal halves the budget, never below one step
            if (!first && dir != rev_q) begin
                budget_q = budget_q >> 1;
                if (budget_q == '0)
                    budget_q = STEPS_W'(1);
            end
            rev_q        = dir;
            steps_left_q = budget_q;
            moves_q      = moves_q + MOVES_W'(1);
            status_q     = ST_MOVING;
        end
    endfunction

    // advance the search by one tick and give the result it drives
    function automatic qpsc_result_t advance_search(input logic start,
                                                    input logic [IN_DATA_W-1:0] quads);
        qpsc_result_t r;
        logic [COIL_W-1:0] coil;
        coil = '0;
        if (start) begin
            if (init_steps_q == '0)
                budget_q = STEPS_W'(1);
            else if (init_steps_q > BUDGET_MAX)
                budget_q = BUDGET_MAX;
            else
                budget_q = init_steps_q;
            moves_q = '0;
            test_position(quads, 1'b1);
        end else if (status_q == ST_MOVING) begin
            coil    = HALF_STEP_SEQ[{phase_q, 2'b00} +: COIL_W];
            phase_q = rev_q ? phase_q - PHASE_W'(1) : phase_q + PHASE_W'(1);
            if (steps_left_q != '0)
                steps_left_q = steps_left_q - STEPS_W'(1);
            if (steps_left_q == '0)
                test_position(quads, 1'b0);
        end
        r.coil_pattern = coil;
        r.turn_reverse = rev_q;
        r.step_budget  = budget_q;
        r.status       = status_q;
        return r;
    endfunction

    // watch both channels and the register port
    always @(posedge aclk) begin
        qpsc_result_t got;
        qpsc_result_t want;
        if (!aresetn) begin
            init_steps_q = INIT_STEPS_RST;
            target_q     = TARGET_RST;
            tol_q        = TOL_RST;
            max_moves_q  = MAX_MOVES_RST;
            phase_q      = '0;
            rev_q        = 1'b0;
            budget_q     = '0;
            steps_left_q = '0;
            moves_q      = '0;
            status_q     = ST_IDLE;
            expected_results.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (qpsc_cfg_idx_t'(cfg_index))
                    CFG_INITIAL_STEPS: init_steps_q = cfg_wdata[STEPS_W-1:0];
                    CFG_TARGET:        target_q     = cfg_wdata[TGT_W-1:0];
                    CFG_TOLERANCE:     tol_q        = cfg_wdata[TOL_W-1:0];
                    CFG_MAX_MOVES:     max_moves_q  = cfg_wdata[MOVES_W-1:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest expectation
            if (m_tvalid && m_tready) begin
                got = qpsc_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, tdata", int'(m_tdata), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.coil_pattern !== want.coil_pattern)
                        report_mismatch("coil_pattern", got.coil_pattern, want.coil_pattern);
                    if (got.turn_reverse !== want.turn_reverse)
                        report_mismatch("turn_reverse", got.turn_reverse, want.turn_reverse);
                    if (got.step_budget !== want.step_budget)
                        report_mismatch("step_budget", got.step_budget, want.step_budget);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                end
                result_index++;
            end
            // input transaction
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_search(s_tuser, s_tdata));
        end
        outstanding = expected_results.size();
    end

endmodule

[sim/tb_quad_photodiode_stepper_centering.sv]
// testbench top: reset, register settings, tick stimulus and verdict
`timescale 1ns / 1ps

module tb_quad_photodiode_stepper_centering;
    import qpsc_pkg::*;

    localparam int SEGMENT_ITEMS = 225;
    localparam logic [SAMPLE_BITS-1:0] FULL = '1;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we    = 1'b0;
    qpsc_cfg_idx_t          cfg_index = CFG_INITIAL_STEPS;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count;
    int pending_results;

    quad_photodiode_stepper_centering u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    qpsc_search_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (fail_count),
        .pending   (pending_results)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // receiver back-pressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // run limit
    initial begin
        #2_000_000;
        $display("tb_quad_photodiode_stepper_centering failed");
        $finish;
    end

    function automatic logic [IN_DATA_W-1:0] quads(input int qa, qb, qc, qd);
        return {SAMPLE_BITS'(qd), SAMPLE_BITS'(qc), SAMPLE_BITS'(qb), SAMPLE_BITS'(qa)};
    endfunction

    // random samples: dark, nearly centred, rail values or anything
    function automatic logic [IN_DATA_W-1:0] random_quads();
        int pick;
        int lvl;
        int near;
        pick = $urandom_range(99);
        lvl  = $urandom_range(4093, 2);
        near = lvl + $urandom_range(4, 0) - 2;
        if (pick < 2)
            return '0;
        else if (pick < 12)
            return quads(lvl, near, lvl, near);
        else if (pick < 25)
            return quads($urandom_range(1, 0) * FULL, $urandom_range(1, 0) * FULL,
                         $urandom_range(1, 0) * FULL, $urandom_range(1, 0) * FULL);
        else
            return IN_DATA_W'({$urandom, $urandom});
    endfunction

    // one tick transaction, with random sender gaps before it
    task automatic send_tick(input logic start, input logic [IN_DATA_W-1:0] samples);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= samples;
        do @(posedge aclk); while (!s_tready);
    endtask

    // register write once every result has come back
    task automatic write_reg(input qpsc_cfg_idx_t idx, input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // settings for one segment of random searches
    task automatic choose_settings(input int seg);
        logic [CFG_W-1:0] init_val, tgt_val, tol_val, moves_val;
        init_val  = CFG_W'($urandom_range(24, 2));
        tgt_val   = '0;
        tol_val   = CFG_W'(33);
        moves_val = CFG_W'(65535);
        case (seg % 4)
            0: begin
                init_val = CFG_W'(1);
                tol_val  = '0;
            end
            1: begin
                tgt_val   = CFG_W'($urandom);
                tol_val   = CFG_W'($urandom_range(2000, 0));
                moves_val = CFG_W'($urandom_range(6, 1));
            end
            2: begin
                tgt_val = $urandom_range(1, 0) ? 16'h8000 : 16'h7FFF;
                tol_val = $urandom_range(1, 0) ? CFG_W'(32767) : CFG_W'($urandom_range(32767));
            end
            default: begin
                if ($urandom_range(1, 0))
                    init_val = '0;
                tgt_val   = CFG_W'($urandom_range(6000, 0) - 3000);
                moves_val = CFG_W'($urandom_range(40, 2));
            end
        endcase
        write_reg(CFG_INITIAL_STEPS, init_val);
        write_reg(CFG_TARGET, tgt_val);
        write_reg(CFG_TOLERANCE, tol_val);
        write_reg(CFG_MAX_MOVES, moves_val);
    endtask

    // searches: a start, then a run of plain ticks with the odd stray start
    task automatic run_searches(input int n_items);
        int sent = 0;
        int run_len;
        while (sent < n_items) begin
            send_tick(1'b1, random_quads());
            sent++;
            run_len = $urandom_range(60, 4);
            for (int i = 0; i < run_len && sent < n_items; i++) begin
                send_tick($urandom_range(99) < 3, random_quads());
                sent++;
            end
        end
    endtask

    initial begin
        // reset
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stopped states at the register defaults
        send_tick(1'b0, quads(0, 0, 0, 0));
        send_tick(1'b1, quads(0, 0, 0, 0));
        send_tick(1'b0, quads(FULL, FULL, FULL, FULL));
        send_tick(1'b1, quads(FULL, FULL, FULL, FULL));

        // short moves with reversals, budget halving down to one step
        write_reg(CFG_INITIAL_STEPS, 16'd3);
        write_reg(CFG_TOLERANCE, 16'd0);
        send_tick(1'b1, quads(FULL, 0, FULL, 0));
        send_tick(1'b0, quads(1, 2, 3, 4));
        send_tick(1'b0, quads(5, 9, 7, 11));
        send_tick(1'b0, quads(0, FULL, 0, FULL));
        send_tick(1'b0, quads(FULL, 0, FULL, 0));
        send_tick(1'b0, quads(100, 100, 100, 100));

        // move limit: none allowed, then exactly one
        write_reg(CFG_MAX_MOVES, 16'd0);
        send_tick(1'b1, quads(FULL, 0, 0, 0));
        write_reg(CFG_MAX_MOVES, 16'd1);
        send_tick(1'b1, quads(0, 0, 0, FULL));
        send_tick(1'b0, quads(0, 0, 0, FULL));
        send_tick(1'b0, quads(0, 0, 0, FULL));
        send_tick(1'b0, quads(FULL, 0, 0, 0));

        // zero initial budget, most negative target, widest tolerance
        write_reg(CFG_INITIAL_STEPS, 16'd0);
        write_reg(CFG_TARGET, 16'h8000);
        write_reg(CFG_TOLERANCE, 16'd32767);
        write_reg(CFG_MAX_MOVES, 16'd65535);
        send_tick(1'b1, quads(FULL, FULL, FULL, FULL));
        send_tick(1'b0, quads(0, FULL, 0, 0));

        // oversized initial budget, most positive target
        write_reg(CFG_TARGET, 16'h7FFF);
        write_reg(CFG_INITIAL_STEPS, 16'd8191);
        send_tick(1'b1, quads(1000, 1000, 1000, 1000));

        // random searches over the idling phases
        for (int seg = 0; seg < 8; seg++) begin
            choose_settings(seg);
            case (seg / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            run_searches(SEGMENT_ITEMS);
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_count == 0)
            $display("tb_quad_photodiode_stepper_centering passed");
        else
            $display("tb_quad_photodiode_stepper_centering failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/qpsc_pkg.sv
rtl/core/qpsc_eval.sv
rtl/core/qpsc_seq.sv
rtl/core/quad_photodiode_stepper_centering.sv
sim/qpsc_search_checker.sv
sim/tb_quad_photodiode_stepper_centering.sv
